>>> rtl/core/ils_pkg.sv
package ils_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 5;
  localparam int CNT_W  = 5;

  localparam logic [2:0] OP_GET      = 3'd0;
  localparam logic [2:0] OP_CLEAR    = 3'd1;
  localparam logic [2:0] OP_INSERT   = 3'd2;
  localparam logic [2:0] OP_APPEND   = 3'd3;
  localparam logic [2:0] OP_CONTAINS = 3'd4;
  localparam logic [2:0] OP_SORT     = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]              operation;
    logic [POS_W-1:0]        position;
    logic signed [DATA_W-1:0] data_in;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic                     found;
    logic                     has_next;
    logic [CNT_W-1:0]         entry_count;
    logic [1:0]               status;
  } out_rsp_t;

  typedef enum logic [1:0] {
    WSRC_DIN,
    WSRC_RDATA,
    WSRC_HOLD
  } wsrc_t;

  typedef struct packed {
    logic  rd_en;
    logic  wr_en;
    wsrc_t wr_src;
    logic  v_load;
    logic  dout_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } dp_sts_t;

endpackage

>>> rtl/core/indexed_list_store_unit.sv
// Ordered list of up to DEPTH signed 32-bit entries in a single-port-read RAM.
// A request is taken when start is high and busy is low; its result appears on
// out_rsp with out_valid high for exactly one cycle and must be captured then.
// Clear, append, undefined codes and every range or full error are answered
// straight from the idle state; get reads the entry, then answers; insert at
// the end writes at once, otherwise entries move up one per cycle from the
// last down to position, then data_in is written; contains reads then compares
// per entry and stops at the first match; sort with fewer than two entries
// answers at once, otherwise an insertion sort runs with one pass per entry
// from the second on, each pass shifting larger entries up until the entry
// lands, possibly at the front. The RAM gives one registered read and one
// write per cycle. busy is low again in the result cycle, so the next request
// may be taken there.
module indexed_list_store_unit #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ils_pkg::in_req_t   in_req,
  output logic               out_valid,
  output ils_pkg::out_rsp_t  out_rsp
);

  localparam int AW = $clog2(DEPTH);

  ils_pkg::dp_cmd_t                   cmd;
  ils_pkg::dp_sts_t                   sts;
  logic                               take;
  logic [AW-1:0]                      rd_addr;
  logic [AW-1:0]                      wr_addr;
  logic signed [ils_pkg::DATA_W-1:0]  data_out;
  logic                               found;
  logic                               has_next;
  logic [ils_pkg::CNT_W-1:0]          entry_count;
  logic [1:0]                         status;

  ils_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req      (in_req),
    .busy        (busy),
    .take        (take),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .sts         (sts),
    .out_valid   (out_valid),
    .found       (found),
    .has_next    (has_next),
    .entry_count (entry_count),
    .status      (status)
  );

  ils_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .take     (take),
    .data_in  (in_req.data_in),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .sts      (sts),
    .data_out (data_out)
  );

  always_comb begin
    out_rsp.data_out    = data_out;
    out_rsp.found       = found;
    out_rsp.has_next    = has_next;
    out_rsp.entry_count = entry_count;
    out_rsp.status      = status;
  end

endmodule

>>> rtl/core/ils_datapath.sv
module ils_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 take,
  input  logic signed [ils_pkg::DATA_W-1:0]    data_in,
  input  ils_pkg::dp_cmd_t                     cmd,
  input  logic [$clog2(DEPTH)-1:0]             rd_addr,
  input  logic [$clog2(DEPTH)-1:0]             wr_addr,
  output ils_pkg::dp_sts_t                     sts,
  output logic signed [ils_pkg::DATA_W-1:0]    data_out
);

  logic [ils_pkg::DATA_W-1:0] mem_r [DEPTH];
  logic [ils_pkg::DATA_W-1:0] rdata_r;
  logic [ils_pkg::DATA_W-1:0] din_r;
  logic [ils_pkg::DATA_W-1:0] v_r;
  logic [ils_pkg::DATA_W-1:0] wdata;

  always_comb begin
    case (cmd.wr_src)
      ils_pkg::WSRC_RDATA: wdata = rdata_r;
      ils_pkg::WSRC_HOLD:  wdata = v_r;
      default:             wdata = din_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_r[wr_addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      din_r <= data_in;
    end
    if (cmd.v_load) begin
      v_r <= rdata_r;
    end
  end

  assign sts.eq   = (rdata_r == din_r);
  assign sts.gt   = ($signed(rdata_r) > $signed(v_r));
  assign data_out = cmd.dout_sel ? $signed(rdata_r) : '0;

endmodule

>>> rtl/core/ils_ctrl.sv
module ils_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  ils_pkg::in_req_t                in_req,
  output logic                            busy,
  output logic                            take,
  output ils_pkg::dp_cmd_t                cmd,
  output logic [$clog2(DEPTH)-1:0]        rd_addr,
  output logic [$clog2(DEPTH)-1:0]        wr_addr,
  input  ils_pkg::dp_sts_t                sts,
  output logic                            out_valid,
  output logic                            found,
  output logic                            has_next,
  output logic [ils_pkg::CNT_W-1:0]       entry_count,
  output logic [1:0]                      status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > ils_pkg::POS_W) ? CW : ils_pkg::POS_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_GET,
    S_INS,
    S_INS_LAST,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SRT_V,
    S_SRT_WAIT,
    S_SRT_CMP,
    S_SRT_PUT
  } state_t;

  state_t           state_r, state_nxt;
  ils_pkg::dp_cmd_t cmd_r, cmd_nxt;
  logic [AW-1:0]    rd_addr_r, rd_addr_nxt;
  logic [AW-1:0]    wr_addr_r, wr_addr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    i_r, i_nxt;
  logic [CW-1:0]    j_r, j_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             found_r, found_nxt;
  logic             has_next_r, has_next_nxt;
  logic [1:0]       status_r, status_nxt;

  logic [PW-1:0]    pos_w;
  logic [PW-1:0]    cnt_w;
  logic [CW-1:0]    cnt_p1;
  logic [CW-1:0]    cnt_m1;
  logic [CW-1:0]    pos_p1;
  logic [CW-1:0]    j_m1;
  logic [CW-1:0]    j_m2;
  logic [CW-1:0]    j_p1;
  logic [CW-1:0]    i_m1;
  logic [CW-1:0]    i_p1;

  assign busy = (state_r != S_IDLE);
  assign take = start && !busy;

  always_comb begin
    pos_w  = PW'(in_req.position);
    cnt_w  = PW'(count_r);
    cnt_p1 = count_r + CW'(1);
    cnt_m1 = count_r - CW'(1);
    pos_p1 = CW'(pos_r) + CW'(1);
    j_m1   = j_r - CW'(1);
    j_m2   = j_r - CW'(2);
    j_p1   = j_r + CW'(1);
    i_m1   = i_r - CW'(1);
    i_p1   = i_r + CW'(1);
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = '0;
    rd_addr_nxt   = rd_addr_r;
    wr_addr_nxt   = wr_addr_r;
    count_nxt     = count_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    pos_nxt       = pos_r;
    out_valid_nxt = 1'b0;
    found_nxt     = 1'b0;
    has_next_nxt  = 1'b0;
    status_nxt    = ils_pkg::ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          unique case (in_req.operation)
            ils_pkg::OP_GET: begin
              if (pos_w < cnt_w) begin
                cmd_nxt.rd_en = 1'b1;
                rd_addr_nxt   = pos_w[AW-1:0];
                pos_nxt       = pos_w[AW-1:0];
                state_nxt     = S_GET;
              end else begin
                out_valid_nxt = 1'b1;
                status_nxt    = ils_pkg::ST_RANGE;
              end
            end
            ils_pkg::OP_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            ils_pkg::OP_INSERT: begin
              if (pos_w > cnt_w) begin
                out_valid_nxt = 1'b1;
                status_nxt    = ils_pkg::ST_RANGE;
              end else if (count_r == FULL_CNT) begin
                out_valid_nxt = 1'b1;
                status_nxt    = ils_pkg::ST_FULL;
              end else if (pos_w == cnt_w) begin
                cmd_nxt.wr_en  = 1'b1;
                cmd_nxt.wr_src = ils_pkg::WSRC_DIN;
                wr_addr_nxt    = pos_w[AW-1:0];
                count_nxt      = cnt_p1;
                out_valid_nxt  = 1'b1;
              end else begin
                pos_nxt       = pos_w[AW-1:0];
                cmd_nxt.rd_en = 1'b1;
                rd_addr_nxt   = cnt_m1[AW-1:0];
                j_nxt         = cnt_m1;
                state_nxt     = S_INS;
              end
            end
            ils_pkg::OP_APPEND: begin
              out_valid_nxt = 1'b1;
              if (count_r == FULL_CNT) begin
                status_nxt = ils_pkg::ST_FULL;
              end else begin
                cmd_nxt.wr_en  = 1'b1;
                cmd_nxt.wr_src = ils_pkg::WSRC_DIN;
                wr_addr_nxt    = count_r[AW-1:0];
                count_nxt      = cnt_p1;
              end
            end
            ils_pkg::OP_CONTAINS: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                cmd_nxt.rd_en = 1'b1;
                rd_addr_nxt   = '0;
                j_nxt         = '0;
                state_nxt     = S_SRCH_RD;
              end
            end
            ils_pkg::OP_SORT: begin
              if (count_r < CW'(2)) begin
                out_valid_nxt = 1'b1;
              end else begin
                cmd_nxt.rd_en = 1'b1;
                rd_addr_nxt   = AW'(1);
                i_nxt         = CW'(1);
                state_nxt     = S_SRT_V;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_GET: begin
        cmd_nxt.dout_sel = 1'b1;
        out_valid_nxt    = 1'b1;
        has_next_nxt     = (pos_p1 < count_r);
        state_nxt        = S_IDLE;
      end
      S_INS: begin
        cmd_nxt.wr_en  = 1'b1;
        cmd_nxt.wr_src = ils_pkg::WSRC_RDATA;
        wr_addr_nxt    = j_p1[AW-1:0];
        if (j_r > CW'(pos_r)) begin
          cmd_nxt.rd_en = 1'b1;
          rd_addr_nxt   = j_m1[AW-1:0];
          j_nxt         = j_m1;
        end else begin
          state_nxt = S_INS_LAST;
        end
      end
      S_INS_LAST: begin
        cmd_nxt.wr_en  = 1'b1;
        cmd_nxt.wr_src = ils_pkg::WSRC_DIN;
        wr_addr_nxt    = pos_r;
        count_nxt      = cnt_p1;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_SRCH_RD: begin
        state_nxt = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (sts.eq) begin
          out_valid_nxt = 1'b1;
          found_nxt     = 1'b1;
          state_nxt     = S_IDLE;
        end else if (j_p1 < count_r) begin
          cmd_nxt.rd_en = 1'b1;
          rd_addr_nxt   = j_p1[AW-1:0];
          j_nxt         = j_p1;
          state_nxt     = S_SRCH_RD;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SRT_V: begin
        cmd_nxt.v_load = 1'b1;
        cmd_nxt.rd_en  = 1'b1;
        rd_addr_nxt    = i_m1[AW-1:0];
        j_nxt          = i_r;
        state_nxt      = S_SRT_WAIT;
      end
      S_SRT_WAIT: begin
        state_nxt = S_SRT_CMP;
      end
      S_SRT_CMP: begin
        cmd_nxt.wr_en = 1'b1;
        wr_addr_nxt   = j_r[AW-1:0];
        if (sts.gt) begin
          cmd_nxt.wr_src = ils_pkg::WSRC_RDATA;
          j_nxt          = j_m1;
          if (j_m1 != '0) begin
            cmd_nxt.rd_en = 1'b1;
            rd_addr_nxt   = j_m2[AW-1:0];
            state_nxt     = S_SRT_WAIT;
          end else begin
            state_nxt = S_SRT_PUT;
          end
        end else begin
          cmd_nxt.wr_src = ils_pkg::WSRC_HOLD;
          if (i_p1 < count_r) begin
            cmd_nxt.rd_en = 1'b1;
            rd_addr_nxt   = i_p1[AW-1:0];
            i_nxt         = i_p1;
            state_nxt     = S_SRT_V;
          end else begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      S_SRT_PUT: begin
        cmd_nxt.wr_en  = 1'b1;
        cmd_nxt.wr_src = ils_pkg::WSRC_HOLD;
        wr_addr_nxt    = j_r[AW-1:0];
        if (i_p1 < count_r) begin
          cmd_nxt.rd_en = 1'b1;
          rd_addr_nxt   = i_p1[AW-1:0];
          i_nxt         = i_p1;
          state_nxt     = S_SRT_V;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmd_r       <= '0;
      rd_addr_r   <= '0;
      wr_addr_r   <= '0;
      count_r     <= '0;
      i_r         <= '0;
      j_r         <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      has_next_r  <= 1'b0;
      status_r    <= ils_pkg::ST_OK;
    end else begin
      state_r     <= state_nxt;
      cmd_r       <= cmd_nxt;
      rd_addr_r   <= rd_addr_nxt;
      wr_addr_r   <= wr_addr_nxt;
      count_r     <= count_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      has_next_r  <= has_next_nxt;
      status_r    <= status_nxt;
    end
  end

  assign cmd         = cmd_r;
  assign rd_addr     = rd_addr_r;
  assign wr_addr     = wr_addr_r;
  assign out_valid   = out_valid_r;
  assign found       = found_r;
  assign has_next    = has_next_r;
  assign status      = status_r;
  assign entry_count = cnt_w[ils_pkg::CNT_W-1:0];

endmodule

>>> rtl/core/ils_checker.sv
module ils_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input ils_pkg::in_req_t   in_req,
  input logic               out_valid,
  input ils_pkg::out_rsp_t  out_rsp
);

  // every taken request yields a result next cycle or holds the unit busy
  a_req_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("request neither answered nor in progress");

  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status != ils_pkg::ST_OK |->
      !out_rsp.found && !out_rsp.has_next && out_rsp.data_out == '0)
    else $error("error result carries payload");

  a_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.found |->
      out_rsp.status == ils_pkg::ST_OK && out_rsp.data_out == '0 && !out_rsp.has_next)
    else $error("contains result carries get fields");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rsp.status == ils_pkg::ST_OK || out_rsp.status == ils_pkg::ST_RANGE ||
      out_rsp.status == ils_pkg::ST_FULL)
    else $error("illegal status code");

endmodule

bind indexed_list_store_unit ils_checker u_ils_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);
